// File: rtl/core/sacl_pkg.sv
// Shared types, constants and register codes for the set-associative cache core.
package sacl_pkg;

	// Default sizing of the line store
	localparam int DEF_MAX_SETS  = 256;
	localparam int DEF_MAX_WAYS  = 8;
	localparam int DEF_ADDR_BITS = 32;

	// Way index field in the scan interface, wide enough for the largest way count
	localparam int MAX_WAYS_HIGH = 16;
	localparam int WAY_IDX_W     = $clog2(MAX_WAYS_HIGH);

	// Fixed field widths
	localparam int STAMP_W     = 32;
	localparam int COUNT_W     = 32;
	localparam int CFG_SET_W   = 4;
	localparam int CFG_OFF_W   = 5;
	localparam int CFG_WAYS_W  = 4;
	localparam int CFG_COST_W  = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int WAY_OUT_W   = 3;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OFF_BITS  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HIT_COST  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_MISS_COST = 3'd4;

	// Register reset values
	localparam logic [CFG_SET_W-1:0]  RST_SET_BITS  = 4'd0;
	localparam logic [CFG_OFF_W-1:0]  RST_OFF_BITS  = 5'd0;
	localparam logic [CFG_WAYS_W-1:0] RST_WAYS      = 4'd1;
	localparam logic [CFG_COST_W-1:0] RST_HIT_COST  = 16'd4;
	localparam logic [CFG_COST_W-1:0] RST_MISS_COST = 16'd100;

	// Control into the scan unit for one line read
	typedef struct packed {
		logic                 start;
		logic                 valid;
		logic [WAY_IDX_W-1:0] way;
	} scan_ctl_t;

	// Outcome of a full set scan
	typedef struct packed {
		logic                 hit;
		logic                 free;
		logic [WAY_IDX_W-1:0] hit_way;
		logic [WAY_IDX_W-1:0] free_way;
		logic [WAY_IDX_W-1:0] lru_way;
	} scan_res_t;

endpackage

// File: rtl/core/sacl_ram.sv
// Single-write, single-read line store with registered read data.
module sacl_ram #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 65
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/sacl_scan.sv
// Shared compare unit: checks one line per cycle for tag hit, free way and oldest stamp.
module sacl_scan import sacl_pkg::*; #(
	parameter int TAG_W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scan_ctl_t          ctl,
	input  logic               line_valid,
	input  logic [TAG_W-1:0]   line_tag,
	input  logic [STAMP_W-1:0] line_stamp,
	input  logic [TAG_W-1:0]   ref_tag,
	output scan_res_t          res
);

	logic                 hit_q;
	logic                 free_q;
	logic [WAY_IDX_W-1:0] hit_way_q;
	logic [WAY_IDX_W-1:0] free_way_q;
	logic [WAY_IDX_W-1:0] lru_way_q;
	logic [STAMP_W-1:0]   best_stamp_q;

	logic tag_eq;
	logic older;
	logic first_way;

	// Compare the current line against the lookup tag and the oldest stamp so far
	assign tag_eq    = (line_tag == ref_tag);
	assign older     = (line_stamp < best_stamp_q);
	assign first_way = (ctl.way == '0);

	// Hold the first hit and the first free way, track the oldest stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.valid) begin
			if (!hit_q && line_valid && tag_eq) begin
				hit_q <= 1'b1;
			end
			if (!free_q && !line_valid) begin
				free_q <= 1'b1;
			end
		end
	end

	// Way indexes and best stamp need no reset
	always_ff @(posedge clk) begin
		if (ctl.valid && !ctl.start) begin
			if (!hit_q && line_valid && tag_eq) begin
				hit_way_q <= ctl.way;
			end
			if (!free_q && !line_valid) begin
				free_way_q <= ctl.way;
			end
			if (first_way || older) begin
				best_stamp_q <= line_stamp;
				lru_way_q    <= ctl.way;
			end
		end
	end

	assign res.hit      = hit_q;
	assign res.free     = free_q;
	assign res.hit_way  = hit_way_q;
	assign res.free_way = free_way_q;
	assign res.lru_way  = lru_way_q;

endmodule

// File: rtl/core/set_assoc_cache_lru_sim_core.sv
// Top level of the set-associative cache core with least-recently-used replacement.
//
//  channel  direction  handshake           payload
//  input    in         in_valid/in_stall   address
//  output   out        out_valid/out_stall hit, way_used, hit_total, miss_total, cycle_total
//  config   in         cfg_we              cfg_index, cfg_data
//
// An access runs from acceptance in the idle state through the scan state, which reads the
// lines of the set through the single read port of the line store and the shared compare
// unit, to the write-back state, after which the next access is accepted.
// After reset a clearing pass writes every line, MAX_SETS * MAX_WAYS lines (2048 by
// default); no access is taken meanwhile, configuration writes are.
// A finished result waits in the output register; the next access is accepted then, and
// its write-back holds until the output register is free.
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
	parameter int MAX_SETS  = DEF_MAX_SETS,
	parameter int MAX_WAYS  = DEF_MAX_WAYS,
	parameter int ADDR_BITS = DEF_ADDR_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            address,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic [WAY_OUT_W-1:0]   way_used,
	output logic [COUNT_W-1:0]     hit_total,
	output logic [COUNT_W-1:0]     miss_total,
	output logic [COUNT_W-1:0]     cycle_total
);

	localparam int AW        = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int LINES     = MAX_SETS * MAX_WAYS;
	localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SET_LIMIT = $clog2(MAX_SETS + 1) - 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam int ENTRY_W   = 1 + AW + STAMP_W;
	localparam int SHIFT_W   = 6;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_WRITE = 2'd3;

	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
	                                               input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
	endfunction

	// Configuration registers
	logic [CFG_SET_W-1:0]  set_bits_q;
	logic [CFG_OFF_W-1:0]  off_bits_q;
	logic [CFG_WAYS_W-1:0] ways_cfg_q;
	logic [CFG_COST_W-1:0] hit_cost_q;
	logic [CFG_COST_W-1:0] miss_cost_q;

	// Sequencer and per-access registers
	logic [1:0]          state_q;
	logic [LINE_W-1:0]   clr_q;
	logic [LINE_W-1:0]   base_q;
	logic [AW-1:0]       tag_q;
	logic [WCNT_W-1:0]   ways_q;
	logic [WCNT_W-1:0]   rd_cnt_q;
	logic [STAMP_W-1:0]  clock_q;
	logic                pend_s1;
	logic                last_s1;
	logic [WAY_W-1:0]    way_s1;

	// Counters and output register
	logic [COUNT_W-1:0]   hit_cnt_q;
	logic [COUNT_W-1:0]   miss_cnt_q;
	logic [COUNT_W-1:0]   cyc_cnt_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic [WAY_OUT_W-1:0] way_used_q;

	// Address split
	logic [AW-1:0]        addr_m;
	logic [CFG_SET_W-1:0] sbits;
	logic [SHIFT_W-1:0]   shift;
	logic [AW-1:0]        off_shifted;
	logic [SET_W-1:0]     set_idx;
	logic [AW-1:0]        tag_new;
	logic [WCNT_W-1:0]    ways_eff;

	// Line store and scan signals
	logic               accept;
	logic               out_free;
	logic               issue;
	logic               commit;
	logic               mem_we;
	logic [LINE_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [LINE_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;
	scan_ctl_t          scan_ctl;
	scan_res_t          scan_res;
	logic [WAY_IDX_W-1:0] way_pick;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < ways_q);
	assign commit   = (state_q == ST_WRITE) && out_free;

	// Split the address into set and tag under the clipped field widths
	assign addr_m      = AW'(address);
	assign sbits       = (set_bits_q > CFG_SET_W'(SET_LIMIT)) ? CFG_SET_W'(SET_LIMIT)
	                                                          : set_bits_q;
	assign shift       = SHIFT_W'(off_bits_q) + SHIFT_W'(sbits);
	assign off_shifted = addr_m >> off_bits_q;
	assign set_idx     = SET_W'(off_shifted) & ~({SET_W{1'b1}} << sbits);
	assign tag_new     = addr_m >> shift;

	// Clip the way count to one up to the configured maximum
	always_comb begin
		if (ways_cfg_q == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (int'(ways_cfg_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_cfg_q);
		end
	end

	// Pick the way to refresh, fill or replace
	always_comb begin
		if (scan_res.hit) begin
			way_pick = scan_res.hit_way;
		end else if (scan_res.free) begin
			way_pick = scan_res.free_way;
		end else begin
			way_pick = scan_res.lru_way;
		end
	end

	// Line store port selection: clearing pass or write-back
	assign mem_we    = (state_q == ST_CLEAR) || commit;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : (base_q + LINE_W'(way_pick));
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, tag_q, clock_q};
	assign mem_raddr = base_q + LINE_W'(rd_cnt_q);

	sacl_ram #(
		.DEPTH (LINES),
		.ADDR_W(LINE_W),
		.DATA_W(ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign scan_ctl.start = accept;
	assign scan_ctl.valid = pend_s1;
	assign scan_ctl.way   = WAY_IDX_W'(way_s1);

	sacl_scan #(
		.TAG_W(AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.line_valid(mem_rdata[ENTRY_W-1]),
		.line_tag  (mem_rdata[ENTRY_W-2 -: AW]),
		.line_stamp(mem_rdata[STAMP_W-1:0]),
		.ref_tag   (tag_q),
		.res       (scan_res)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q  <= RST_SET_BITS;
			off_bits_q  <= RST_OFF_BITS;
			ways_cfg_q  <= RST_WAYS;
			hit_cost_q  <= RST_HIT_COST;
			miss_cost_q <= RST_MISS_COST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SET_BITS:  set_bits_q  <= cfg_data[CFG_SET_W-1:0];
				REG_OFF_BITS:  off_bits_q  <= cfg_data[CFG_OFF_W-1:0];
				REG_WAYS:      ways_cfg_q  <= cfg_data[CFG_WAYS_W-1:0];
				REG_HIT_COST:  hit_cost_q  <= cfg_data[CFG_COST_W-1:0];
				REG_MISS_COST: miss_cost_q <= cfg_data[CFG_COST_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: clear, wait, scan the set, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			rd_cnt_q <= '0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LINE_W'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rd_cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (pend_s1 && last_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the access and advance the read pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= LINE_W'(set_idx) * LINE_W'(MAX_WAYS);
			tag_q   <= tag_new;
			ways_q  <= ways_eff;
		end
		way_s1  <= WAY_W'(rd_cnt_q);
		last_s1 <= (rd_cnt_q == ways_q - 1'b1);
	end

	// Access clock and saturating counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q    <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			cyc_cnt_q  <= '0;
		end else begin
			if (accept) begin
				clock_q <= clock_q + 1'b1;
			end
			if (commit) begin
				if (scan_res.hit) begin
					hit_cnt_q <= sat_add(hit_cnt_q, COUNT_W'(1));
					cyc_cnt_q <= sat_add(cyc_cnt_q, COUNT_W'(hit_cost_q));
				end else begin
					miss_cnt_q <= sat_add(miss_cnt_q, COUNT_W'(1));
					cyc_cnt_q  <= sat_add(cyc_cnt_q, COUNT_W'(miss_cost_q));
				end
			end
		end
	end

	// Output register: drop on transaction, load on write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q      <= scan_res.hit;
			way_used_q <= WAY_OUT_W'(way_pick);
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign way_used    = way_used_q;
	assign hit_total   = hit_cnt_q;
	assign miss_total  = miss_cnt_q;
	assign cycle_total = cyc_cnt_q;

endmodule
